>>> rtl/bcd_adjust_unit_top_assert.svh
// Assertion macros for the decimal-adjust unit checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BCD_ADJUST_UNIT_TOP_ASSERT_SVH
`define BCD_ADJUST_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bau_pkg.sv
// Shared types, constants and helper functions of the decimal-adjust unit.
// Used by every RTL module of the block; depends on nothing.
`timescale 1ns / 1ps

package bau_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int DIV_STEPS   = 8;

  localparam logic [2:0] OP_AAA = 3'd0;
  localparam logic [2:0] OP_AAS = 3'd1;
  localparam logic [2:0] OP_DAA = 3'd2;
  localparam logic [2:0] OP_DAS = 3'd3;
  localparam logic [2:0] OP_AAM = 3'd4;
  localparam logic [2:0] OP_AAD = 3'd5;

  localparam logic [3:0] NIB_MAX = 4'd9;
  localparam logic [3:0] NIB_ADJ = 4'h6;
  localparam logic [7:0] DEC_MAX = 8'h99;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  typedef enum logic [6:0] {
    CLS_AAA  = 7'b0000001,
    CLS_AAS  = 7'b0000010,
    CLS_DAA  = 7'b0000100,
    CLS_DAS  = 7'b0001000,
    CLS_AAM  = 7'b0010000,
    CLS_AAD  = 7'b0100000,
    CLS_PASS = 7'b1000000
  } bau_cls_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] al_in;
    logic [7:0] ah_in;
    logic       af_in;
    logic       cf_in;
    logic [7:0] imm_base;
  } bau_in_t;

  typedef struct packed {
    logic [7:0] al_out;
    logic [7:0] ah_out;
    logic       af_out;
    logic       cf_out;
    logic       sign_flag;
    logic       zero_flag;
    logic       parity_flag;
    logic       szp_written;
    logic       divide_error;
  } bau_out_t;

  // Classified instruction as it travels from the front end to the back end.
  typedef struct packed {
    bau_cls_t   cls;
    logic [7:0] al;
    logic [7:0] ah;
    logic       af;
    logic       cf;
    logic [7:0] imm;
    logic       lo_adj;
    logic       hi_adj;
    logic       derr;
  } bau_dec_t;

  // One stage of the back-end pipeline; rem doubles as the AAD product.
  typedef struct packed {
    bau_cls_t   cls;
    logic [7:0] al;
    logic [7:0] ah;
    logic       af;
    logic       cf;
    logic       derr;
    logic       szp;
    logic [7:0] imm;
    logic [7:0] rem;
    logic [7:0] dq;
  } bau_stage_t;

  function automatic logic even_parity(input logic [7:0] v);
    return ~^v;
  endfunction

  // One restoring-division step: shift in a dividend bit, shift out a quotient bit.
  function automatic bau_stage_t div_step(input bau_stage_t s);
    bau_stage_t r;
    logic [8:0] t;
    logic [8:0] d;
    r = s;
    t = {s.rem, s.dq[7]};
    d = t - {1'b0, s.imm};
    if (s.cls == CLS_AAM) begin
      if (t >= {1'b0, s.imm}) begin
        r.rem = d[7:0];
        r.dq  = {s.dq[6:0], 1'b1};
      end else begin
        r.rem = t[7:0];
        r.dq  = {s.dq[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/bau_front.sv
// Front end of the decimal-adjust unit: accepts instructions and classifies them.
// Depends on bau_pkg for the payload and decoded-item types.
`timescale 1ns / 1ps

module bau_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bau_pkg::bau_in_t  in_data,
  output logic              dec_vld,
  input  logic              dec_rdy,
  output bau_pkg::bau_dec_t dec_data
);

  logic              vld_r;
  logic              vld_nxt;
  bau_pkg::bau_dec_t dec_r;
  bau_pkg::bau_dec_t dec_nxt;

  assign in_ready = !vld_r || dec_rdy;
  assign dec_vld  = vld_r;
  assign dec_data = dec_r;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_comb begin
    case (in_data.operation)
      bau_pkg::OP_AAA: dec_nxt.cls = bau_pkg::CLS_AAA;
      bau_pkg::OP_AAS: dec_nxt.cls = bau_pkg::CLS_AAS;
      bau_pkg::OP_DAA: dec_nxt.cls = bau_pkg::CLS_DAA;
      bau_pkg::OP_DAS: dec_nxt.cls = bau_pkg::CLS_DAS;
      bau_pkg::OP_AAM: dec_nxt.cls = bau_pkg::CLS_AAM;
      bau_pkg::OP_AAD: dec_nxt.cls = bau_pkg::CLS_AAD;
      default:         dec_nxt.cls = bau_pkg::CLS_PASS;
    endcase
    dec_nxt.al     = in_data.al_in;
    dec_nxt.ah     = in_data.ah_in;
    dec_nxt.af     = in_data.af_in;
    dec_nxt.cf     = in_data.cf_in;
    dec_nxt.imm    = in_data.imm_base;
    dec_nxt.lo_adj = (in_data.al_in[3:0] > bau_pkg::NIB_MAX) || in_data.af_in;
    dec_nxt.hi_adj = (in_data.al_in > bau_pkg::DEC_MAX) || in_data.cf_in;
    dec_nxt.derr   = (in_data.operation == bau_pkg::OP_AAM) &&
                     (in_data.imm_base == bau_pkg::BYTE_ZERO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

>>> rtl/bau_queue.sv
// Short queue of classified instructions between the front and back ends.
// Depends on bau_pkg for the decoded-item type.
`timescale 1ns / 1ps

module bau_queue #(
  parameter int DEPTH = bau_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_vld,
  output logic              push_rdy,
  input  bau_pkg::bau_dec_t push_data,
  output logic              pop_vld,
  input  logic              pop_rdy,
  output bau_pkg::bau_dec_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bau_pkg::bau_dec_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_rdy = (cnt_r != CNT_W'(DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/bau_back.sv
// Back end of the decimal-adjust unit: adjust logic, pipelined divider and result register.
// Depends on bau_pkg for the stage type, division step and parity function.
`timescale 1ns / 1ps

module bau_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_vld,
  output logic              q_pop,
  input  bau_pkg::bau_dec_t q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bau_pkg::bau_out_t out_data
);

  localparam int NSTG = bau_pkg::DIV_STEPS + 1;

  bau_pkg::bau_stage_t st_r   [NSTG];
  bau_pkg::bau_stage_t st_nxt [NSTG];
  logic [NSTG-1:0]     vld_r;
  logic [NSTG-1:0]     vld_nxt;
  logic                out_vld_r;
  logic                out_vld_nxt;
  bau_pkg::bau_out_t   out_r;
  bau_pkg::bau_out_t   out_nxt;
  logic                adv;
  logic [7:0]          adj;
  logic [15:0]         prod;
  bau_pkg::bau_stage_t last;
  logic [7:0]          fin_al;

  assign adv       = !out_vld_r || out_ready;
  assign q_pop     = adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign adj       = {q_data.hi_adj ? bau_pkg::NIB_ADJ : 4'h0,
                      q_data.lo_adj ? bau_pkg::NIB_ADJ : 4'h0};
  assign prod      = 16'(q_data.ah) * 16'(q_data.imm);
  assign last      = st_r[NSTG-1];

  always_comb begin
    st_nxt[0].cls  = q_data.cls;
    st_nxt[0].al   = q_data.al;
    st_nxt[0].ah   = q_data.ah;
    st_nxt[0].af   = q_data.af;
    st_nxt[0].cf   = q_data.cf;
    st_nxt[0].derr = q_data.derr;
    st_nxt[0].szp  = 1'b0;
    st_nxt[0].imm  = q_data.imm;
    st_nxt[0].rem  = bau_pkg::BYTE_ZERO;
    st_nxt[0].dq   = q_data.al;
    case (q_data.cls)
      bau_pkg::CLS_AAA: begin
        if (q_data.lo_adj) begin
          st_nxt[0].al = {4'h0, q_data.al[3:0] + bau_pkg::NIB_ADJ};
          st_nxt[0].ah = q_data.ah + 8'd1;
        end else begin
          st_nxt[0].al = {4'h0, q_data.al[3:0]};
        end
        st_nxt[0].af = q_data.lo_adj;
        st_nxt[0].cf = q_data.lo_adj;
      end
      bau_pkg::CLS_AAS: begin
        if (q_data.lo_adj) begin
          st_nxt[0].al = {4'h0, q_data.al[3:0] - bau_pkg::NIB_ADJ};
          st_nxt[0].ah = q_data.ah - 8'd1;
        end else begin
          st_nxt[0].al = {4'h0, q_data.al[3:0]};
        end
        st_nxt[0].af = q_data.lo_adj;
        st_nxt[0].cf = q_data.lo_adj;
      end
      bau_pkg::CLS_DAA: begin
        st_nxt[0].al = q_data.al + adj;
        st_nxt[0].af = q_data.lo_adj;
        st_nxt[0].cf = q_data.hi_adj;
      end
      bau_pkg::CLS_DAS: begin
        st_nxt[0].al = q_data.al - adj;
        st_nxt[0].af = q_data.lo_adj;
        st_nxt[0].cf = q_data.hi_adj;
      end
      bau_pkg::CLS_AAM: begin
        st_nxt[0].szp = !q_data.derr;
      end
      bau_pkg::CLS_AAD: begin
        st_nxt[0].ah  = bau_pkg::BYTE_ZERO;
        st_nxt[0].rem = prod[7:0];
        st_nxt[0].szp = 1'b1;
      end
      default: begin
      end
    endcase
    for (int k = 1; k < NSTG; k++) begin
      st_nxt[k] = bau_pkg::div_step(st_r[k-1]);
    end
  end

  assign vld_nxt = {vld_r[NSTG-2:0], q_vld};

  always_comb begin
    case (last.cls)
      bau_pkg::CLS_AAM: fin_al = last.derr ? last.al : last.rem;
      bau_pkg::CLS_AAD: fin_al = last.al + last.rem;
      default:          fin_al = last.al;
    endcase
    out_nxt.al_out       = fin_al;
    out_nxt.ah_out       = (last.cls == bau_pkg::CLS_AAM && !last.derr) ? last.dq : last.ah;
    out_nxt.af_out       = last.af;
    out_nxt.cf_out       = last.cf;
    out_nxt.sign_flag    = last.szp && fin_al[7];
    out_nxt.zero_flag    = last.szp && (fin_al == bau_pkg::BYTE_ZERO);
    out_nxt.parity_flag  = last.szp && bau_pkg::even_parity(fin_al);
    out_nxt.szp_written  = last.szp;
    out_nxt.divide_error = last.derr;
  end

  assign out_vld_nxt = adv ? vld_r[NSTG-1] : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        vld_r <= vld_nxt;
      end
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NSTG; k++) begin
        st_r[k] <= st_nxt[k];
      end
      out_r <= out_nxt;
    end
  end

endmodule

>>> rtl/bcd_adjust_unit_top.sv
// Top level of the decimal-adjust unit for AAA, AAS, DAA, DAS, AAM and AAD.
// Depends on bau_pkg, bau_front, bau_queue and bau_back.
//
// Usage:
// The input channel (in_valid, in_ready, in_data) takes one instruction beat with
// its opcode, AL, AH, AF, CF and immediate byte. The result channel (out_valid,
// out_ready, out_data) returns exactly one beat per instruction, in order.
// A front end classifies each instruction and precomputes the adjust conditions,
// a four-entry queue decouples it from the back end, and the back end runs every
// instruction through an eight-stage restoring divider used by AAM.
// Throughput is one instruction per cycle while out_ready stays high.
// With the queue empty, an accepted input beat passes through one front
// register, one queue write, one entry stage, eight divider stages and the
// result register before its result appears on out_valid.
// When the receiver stalls, the back end holds its stages and its result, the
// queue fills, and in_ready drops only once the queue and front register are full.
// A synchronous active-low reset empties the pipeline and the queue; the block
// keeps no architectural state, so no result depends on earlier instructions.
`timescale 1ns / 1ps

module bcd_adjust_unit_top #(
  parameter int QUEUE_DEPTH = bau_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bau_pkg::bau_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bau_pkg::bau_out_t out_data
);

  logic              dec_vld;
  logic              dec_rdy;
  bau_pkg::bau_dec_t dec_data;
  logic              q_vld;
  logic              q_pop;
  bau_pkg::bau_dec_t q_data;

  bau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dec_vld  (dec_vld),
    .dec_rdy  (dec_rdy),
    .dec_data (dec_data)
  );

  bau_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (dec_vld),
    .push_rdy  (dec_rdy),
    .push_data (dec_data),
    .pop_vld   (q_vld),
    .pop_rdy   (q_pop),
    .pop_data  (q_data)
  );

  bau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/bau_checker.sv
// Port-level checker for the decimal-adjust unit, bound to the top level.
// Depends on bau_pkg and the macros in bcd_adjust_unit_top_assert.svh.
`timescale 1ns / 1ps
`include "bcd_adjust_unit_top_assert.svh"

module bau_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input bau_pkg::bau_out_t out_data
);

  `BAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "Result beat dropped while stalled.")
  `BAU_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "Result beat changed while stalled.")
  `BAU_ASSERT_NOW(a_derr_no_szp, out_valid && out_data.divide_error, !out_data.szp_written && !out_data.sign_flag && !out_data.zero_flag && !out_data.parity_flag, "Divide error beat reports written flags.")
  `BAU_ASSERT_NOW(a_zero_flag, out_valid && out_data.szp_written, out_data.zero_flag == (out_data.al_out == 8'h00), "Zero flag does not match AL.")
  `BAU_ASSERT_NOW(a_sign_flag, out_valid && out_data.szp_written, out_data.sign_flag == out_data.al_out[7], "Sign flag does not match AL.")

endmodule

bind bcd_adjust_unit_top bau_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> sim/bau_result_checker.sv
// Result checker for the decimal-adjust unit: predicts each result beat from the input beat.
// It compares every output beat in order with its prediction and counts mismatches.
// Depends on bau_pkg for the beat types and operation codes.
`timescale 1ns / 1ps

module bau_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  bau_pkg::bau_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  bau_pkg::bau_out_t out_data,
  output int                mismatch_count,
  output int                results_checked,
  output int                results_due
);
  import bau_pkg::*;

  bau_out_t due_results[$];

  function automatic bau_out_t predict_adjust(input bau_in_t b);
    bau_out_t   r;
    logic [7:0] al;
    logic [7:0] ah;
    logic       af;
    logic       cf;
    logic [8:0] sum9;
    logic       szp;
    logic       derr;
    al = b.al_in;
    ah = b.ah_in;
    af = b.af_in;
    cf = b.cf_in;
    szp = 1'b0;
    derr = 1'b0;
    case (b.operation)
      OP_AAA, OP_AAS: begin
        if (b.al_in[3:0] > 4'd9 || b.af_in) begin
          if (b.operation == OP_AAA) begin
            al = al + 8'd6;
            ah = ah + 8'd1;
          end else begin
            al = al - 8'd6;
            ah = ah - 8'd1;
          end
          af = 1'b1;
          cf = 1'b1;
        end else begin
          af = 1'b0;
          cf = 1'b0;
        end
        al = al & 8'h0F;
      end
      OP_DAA, OP_DAS: begin
        cf = 1'b0;
        if (b.al_in[3:0] > 4'd9 || b.af_in) begin
          if (b.operation == OP_DAA) begin
            sum9 = {1'b0, al} + 9'd6;
            cf = sum9[8];
            al = sum9[7:0];
          end else begin
            cf = (al < 8'd6);
            al = al - 8'd6;
          end
          cf = cf | b.cf_in;
          af = 1'b1;
        end else begin
          af = 1'b0;
        end
        if (b.al_in > 8'h99 || b.cf_in) begin
          if (b.operation == OP_DAA) al = al + 8'h60;
          else al = al - 8'h60;
          cf = 1'b1;
        end else begin
          cf = 1'b0;
        end
      end
      OP_AAM: begin
        if (b.imm_base == 8'd0) begin
          derr = 1'b1;
        end else begin
          ah = b.al_in / b.imm_base;
          al = b.al_in % b.imm_base;
          szp = 1'b1;
        end
      end
      OP_AAD: begin
        al = b.al_in + 8'(b.ah_in * b.imm_base);
        ah = 8'd0;
        szp = 1'b1;
      end
      default: begin
      end
    endcase
    r.al_out       = al;
    r.ah_out       = ah;
    r.af_out       = af;
    r.cf_out       = cf;
    r.sign_flag    = szp & al[7];
    r.zero_flag    = szp & (al == 8'd0);
    r.parity_flag  = szp & ~^al;
    r.szp_written  = szp;
    r.divide_error = derr;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", fname, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    mismatch_count = 0;
    results_checked = 0;
    results_due = 0;
  end

  always @(posedge clk) begin : watch
    bau_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) due_results.push_back(predict_adjust(in_data));
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("Result beat arrived with no instruction outstanding.");
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          check_field("al_out", want.al_out, out_data.al_out);
          check_field("ah_out", want.ah_out, out_data.ah_out);
          check_field("af_out", 8'(want.af_out), 8'(out_data.af_out));
          check_field("cf_out", 8'(want.cf_out), 8'(out_data.cf_out));
          check_field("sign_flag", 8'(want.sign_flag), 8'(out_data.sign_flag));
          check_field("zero_flag", 8'(want.zero_flag), 8'(out_data.zero_flag));
          check_field("parity_flag", 8'(want.parity_flag), 8'(out_data.parity_flag));
          check_field("szp_written", 8'(want.szp_written), 8'(out_data.szp_written));
          check_field("divide_error", 8'(want.divide_error), 8'(out_data.divide_error));
          results_checked++;
        end
      end
      results_due <= due_results.size();
    end
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the decimal-adjust unit: clock, reset, input beats and receiver stalls.
// Prediction and comparison live in bau_result_checker; this module gives the verdict.
// Depends on bau_pkg, bcd_adjust_unit_top and bau_result_checker.
`timescale 1ns / 1ps

module tb_top;
  import bau_pkg::*;

  localparam logic [2:0] OP_RSVD_A = 3'd6;
  localparam logic [2:0] OP_RSVD_B = 3'd7;
  localparam int PHASE_BEATS = 220;
  localparam int HOLD_CYCLES = 80;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  bau_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  bau_out_t out_data;

  int mismatch_count;
  int results_checked;
  int results_due;
  int send_idle_pct;
  int recv_stall_pct;
  int beats_sent;
  bit hold_wanted;
  int hold_left;

  bcd_adjust_unit_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  bau_result_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_checked(results_checked),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still outstanding.", results_due);
    $display("bcd_adjust_unit_top: mismatch");
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic bau_in_t make_beat(input logic [2:0] op, input logic [7:0] al,
                                        input logic [7:0] ah, input logic af,
                                        input logic cf, input logic [7:0] imm);
    bau_in_t b;
    b.operation = op;
    b.al_in     = al;
    b.ah_in     = ah;
    b.af_in     = af;
    b.cf_in     = cf;
    b.imm_base  = imm;
    return b;
  endfunction

  function automatic bau_in_t random_beat();
    bau_in_t b;
    int      pick;
    b.al_in    = 8'($urandom_range(255));
    b.ah_in    = 8'($urandom_range(255));
    b.af_in    = 1'($urandom_range(1));
    b.cf_in    = 1'($urandom_range(1));
    b.imm_base = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 4) b.operation = $urandom_range(1) ? OP_RSVD_A : OP_RSVD_B;
    else b.operation = 3'($urandom_range(5));
    if (b.operation == OP_AAM || b.operation == OP_AAD) begin
      pick = $urandom_range(9);
      if (pick == 0) b.imm_base = 8'd0;
      else if (pick < 5) b.imm_base = 8'd10;
    end
    return b;
  endfunction

  task automatic send_beat(input bau_in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_beat(random_beat());
  endtask

  initial begin : stimulus
    int guard;
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    beats_sent = 0;
    hold_wanted = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(make_beat(OP_AAA, 8'h09, 8'h00, 1'b0, 1'b0, 8'h00));
    send_beat(make_beat(OP_AAA, 8'h0A, 8'h12, 1'b0, 1'b1, 8'h00));
    send_beat(make_beat(OP_AAA, 8'h03, 8'hFF, 1'b1, 1'b0, 8'h00));
    send_beat(make_beat(OP_AAA, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
    send_beat(make_beat(OP_AAS, 8'h0F, 8'h00, 1'b0, 1'b0, 8'h00));
    send_beat(make_beat(OP_AAS, 8'h05, 8'h00, 1'b1, 1'b0, 8'h00));
    send_beat(make_beat(OP_AAS, 8'h09, 8'h34, 1'b0, 1'b1, 8'h00));
    send_beat(make_beat(OP_DAA, 8'h9A, 8'h00, 1'b0, 1'b0, 8'h00));
    send_beat(make_beat(OP_DAA, 8'hFA, 8'h00, 1'b0, 1'b0, 8'h00));
    send_beat(make_beat(OP_DAA, 8'h99, 8'h00, 1'b0, 1'b0, 8'h00));
    send_beat(make_beat(OP_DAA, 8'h12, 8'h00, 1'b1, 1'b1, 8'h00));
    send_beat(make_beat(OP_DAS, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
    send_beat(make_beat(OP_DAS, 8'h9A, 8'h00, 1'b0, 1'b0, 8'h00));
    send_beat(make_beat(OP_DAS, 8'h05, 8'hFF, 1'b1, 1'b1, 8'h00));
    send_beat(make_beat(OP_AAM, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h0A));
    send_beat(make_beat(OP_AAM, 8'h00, 8'h55, 1'b1, 1'b1, 8'h00));
    send_beat(make_beat(OP_AAM, 8'hFF, 8'hAA, 1'b0, 1'b1, 8'h01));
    send_beat(make_beat(OP_AAM, 8'hFF, 8'h00, 1'b1, 1'b0, 8'hFF));
    send_beat(make_beat(OP_AAM, 8'h80, 8'h00, 1'b0, 1'b0, 8'h10));
    send_beat(make_beat(OP_AAD, 8'h09, 8'h09, 1'b0, 1'b0, 8'h0A));
    send_beat(make_beat(OP_AAD, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
    send_beat(make_beat(OP_AAD, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
    send_beat(make_beat(OP_RSVD_A, 8'h5A, 8'hA5, 1'b1, 1'b0, 8'h3C));
    send_beat(make_beat(OP_RSVD_B, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF));

    run_phase(0, 0, PHASE_BEATS);
    run_phase(60, 0, PHASE_BEATS);
    run_phase(0, 60, PHASE_BEATS);
    run_phase(16, 16, PHASE_BEATS);
    hold_wanted = 1'b1;
    run_phase(0, 0, 100);
    in_valid <= 1'b0;

    guard = 0;
    while (results_due != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
    if (results_due != 0) begin
      $error("%0d expected results never arrived.", results_due);
    end

    $display("Sent %0d instruction beats covering all six adjust operations and reserved codes,",
             beats_sent);
    $display("under mixed sender gaps and receiver stalls; %0d results were compared.",
             results_checked);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("bcd_adjust_unit_top: match");
    end else begin
      $display("bcd_adjust_unit_top: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/bau_pkg.sv
rtl/bau_front.sv
rtl/bau_queue.sv
rtl/bau_back.sv
rtl/bcd_adjust_unit_top.sv
rtl/bau_checker.sv
sim/bau_result_checker.sv
sim/tb_top.sv
